// File: hdl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and constants for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

   localparam int Capacity = 16;
   localparam int CntW     = 5;
   localparam int PosW     = 5;
   localparam int ValW     = 32;

   typedef enum logic [2:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_POS  = 3'd2,
      OP_DEL_HEAD = 3'd3,
      OP_DEL_TAIL = 3'd4,
      OP_DEL_POS  = 3'd5,
      OP_READ     = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Broadcast to every cell: shift direction and the 0-based slot it starts at.
   typedef struct packed {
      logic            ins;
      logic            del;
      logic [CntW-1:0] idx;
   } ctrl_type;

endpackage

// File: hdl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One slot of the list: loads the new value, takes a neighbor's value or holds.
// ----------------------------------------------------------------------------
module pol_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  pol_pkg::ctrl_type              ctrl,
   input  logic signed [pol_pkg::ValW-1:0] value_in,
   input  logic signed [pol_pkg::ValW-1:0] left_value,
   input  logic signed [pol_pkg::ValW-1:0] right_value,
   output logic signed [pol_pkg::ValW-1:0] slot_value
);

   localparam logic [pol_pkg::CntW-1:0] MyIdx = pol_pkg::CntW'(CELL_INDEX);

   logic signed [pol_pkg::ValW-1:0] slot_ff;
   logic signed [pol_pkg::ValW-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.ins) begin
         if (MyIdx == ctrl.idx) begin
            slot_in = value_in;
         end else if (MyIdx > ctrl.idx) begin
            slot_in = left_value;
         end
      end else if (ctrl.del) begin
         // close the gap: everything from the removed slot on moves toward the head
         if (MyIdx >= ctrl.idx) begin
            slot_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_value = slot_ff;

endmodule

// File: hdl/positional_ordered_list.sv
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while results drain; each slot cell shifts or holds in parallel.
// A request is taken whenever the result register is empty or drained that cycle.
// Reset clears the entry count and the result valid; slot contents are not cleared.
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list held in a row of slot cells plus an entry count.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
   parameter int CAPACITY = pol_pkg::Capacity
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_operation,
   input  logic [pol_pkg::PosW-1:0]        req_position,
   input  logic signed [pol_pkg::ValW-1:0] req_value_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [pol_pkg::CntW-1:0]        rsp_length,
   output logic signed [pol_pkg::ValW-1:0] rsp_value_out
);

   localparam int IdxW = $clog2(CAPACITY);
   localparam logic [pol_pkg::CntW-1:0] CapCnt = pol_pkg::CntW'(CAPACITY);

   logic signed [pol_pkg::ValW-1:0] slot_vals [CAPACITY];

   logic [pol_pkg::CntW-1:0]        count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pol_pkg::status_type             status_ff, status_in;
   logic [pol_pkg::CntW-1:0]        length_ff, length_in;
   logic signed [pol_pkg::ValW-1:0] vout_ff, vout_in;

   logic                            accept;
   pol_pkg::op_type                 op;
   logic                            pos_ok_ins, pos_ok_del;
   logic                            is_full, is_empty;
   logic [pol_pkg::CntW-1:0]        idx;
   logic                            do_ins, do_del, do_read;
   pol_pkg::ctrl_type               ctrl;
   logic signed [pol_pkg::ValW-1:0] picked;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = pol_pkg::op_type'(req_operation);

   assign is_full    = (count_ff >= CapCnt);
   assign is_empty   = (count_ff == '0);
   assign pos_ok_ins = (req_position != '0) &&
                       ({1'b0, req_position} <= ({1'b0, count_ff} + 6'd1));
   assign pos_ok_del = (req_position != '0) && (req_position <= count_ff);

   always_comb begin
      idx       = req_position - pol_pkg::PosW'(1);
      do_ins    = 1'b0;
      do_del    = 1'b0;
      do_read   = 1'b0;
      status_in = pol_pkg::ST_OK;
      case (op)
         pol_pkg::OP_INS_HEAD: begin
            idx = '0;
            if (is_full) status_in = pol_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         pol_pkg::OP_INS_TAIL: begin
            idx = count_ff;
            if (is_full) status_in = pol_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         pol_pkg::OP_INS_POS: begin
            // position check wins over full
            if (!pos_ok_ins) status_in = pol_pkg::ST_BADPOS;
            else if (is_full) status_in = pol_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         pol_pkg::OP_DEL_HEAD: begin
            idx = '0;
            if (is_empty) status_in = pol_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         pol_pkg::OP_DEL_TAIL: begin
            idx = count_ff - pol_pkg::CntW'(1);
            if (is_empty) status_in = pol_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         pol_pkg::OP_DEL_POS: begin
            if (!pos_ok_del) status_in = pol_pkg::ST_BADPOS;
            else do_del = 1'b1;
         end
         pol_pkg::OP_READ: begin
            if (!pos_ok_del) status_in = pol_pkg::ST_BADPOS;
            else do_read = 1'b1;
         end
         default: begin
            status_in = pol_pkg::ST_BADPOS;
         end
      endcase
   end

   assign ctrl.ins = accept && do_ins;
   assign ctrl.del = accept && do_del;
   assign ctrl.idx = idx;

   assign picked = slot_vals[idx[IdxW-1:0]];

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) count_in = count_ff + pol_pkg::CntW'(1);
      else if (ctrl.del) count_in = count_ff - pol_pkg::CntW'(1);
   end

   assign length_in    = count_in;
   assign vout_in      = (do_del || do_read) ? picked : '0;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [pol_pkg::ValW-1:0] left_v, right_v;
      if (i == 0) begin : g_head
         assign left_v = req_value_in;
      end else begin : g_mid_l
         assign left_v = slot_vals[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_v = slot_vals[i];
      end else begin : g_mid_r
         assign right_v = slot_vals[i+1];
      end
      pol_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .value_in   (req_value_in),
         .left_value (left_v),
         .right_value(right_v),
         .slot_value (slot_vals[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         length_ff <= length_in;
         vout_ff   <= vout_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_length    = length_ff;
   assign rsp_value_out = vout_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCnt)
      else $error("entry count exceeds capacity");

   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && (op == pol_pkg::OP_READ) |=> count_ff == $past(count_ff))
      else $error("read changed the entry count");

   a_length_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_length == count_ff) && rsp_valid)
      else $error("result length does not match entry count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in == pol_pkg::ST_FULL) |-> count_ff == CapCnt)
      else $error("full status with free slots");

   a_no_shift_on_error: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in != pol_pkg::ST_OK) |=> count_ff == $past(count_ff))
      else $error("failed request changed the list");
`endif

endmodule
